// ----- src/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication into the next cycle
`define CHK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpf_pkg
// types, constants and crc helper for the crc-8 escaped packet framer
// ----------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

	localparam logic [7:0] MARKER = 8'hFE;
	localparam logic [7:0] ESCAPE = 8'hFD;
	localparam logic [7:0] FLIP   = 8'h20;
	localparam logic [7:0] POLY   = 8'h8C;
	localparam logic [7:0] INIT   = 8'h00;

	localparam int QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       packet_end;
	} out_item_t;

	// one classified message byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] crc;
		logic       open;
		logic       last;
	} job_t;

	// reflected crc-8, one byte, lsb first
	function automatic logic [7:0] crc_update(input logic [7:0] crc_in,
		input logic [7:0] b);
		logic [7:0] c;
		c = crc_in;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i]) begin
				c = (c >> 1) ^ POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == MARKER) || (b == ESCAPE);
	endfunction

endpackage

`default_nettype wire

// ----- src/crc8_escaped_packet_framer_unit.sv -----
// path: a first line byte passes the queue, job register and output register
// throughput: the serializer emits one line byte per cycle unless stalled, so a
//   message byte gives 1 or 2 line bytes, plus 1 for an opening marker and 2 to
//   3 for crc and closing marker on the last byte of a packet
// reset: arst_n clears crc, packet state, queue count and output valid at once
`default_nettype none

// ----------------------------------------------------------------------------
// crc8_escaped_packet_framer_unit
// byte-stuffing framer: 0xfe markers, 0xfd escapes, reflected crc-8 trailer
// ----------------------------------------------------------------------------
module crc8_escaped_packet_framer_unit #(
	parameter int QUEUE_DEPTH = cpf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// message byte transactions
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire cpf_pkg::in_item_t byte_item,
	// line byte transactions
	output logic                   line_valid,
	input  wire logic              line_stall,
	output cpf_pkg::out_item_t     line_item
);
	import cpf_pkg::*;

	// front to queue
	logic q_push;
	logic q_full;
	job_t q_job;

	// queue to back
	logic q_nonempty;
	logic q_pop;
	job_t q_head;

	// front: crc and packet tagging, one transaction per cycle while queue has room
	cpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_job)
	);

	// decouples the front from output backpressure
	cpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.head     (q_head)
	);

	// back: byte serializer with registered output
	cpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line_item  (line_item)
	);

endmodule

`default_nettype wire

// ----- src/cpf_queue.sv -----
// ----------------------------------------------------------------------------
// cpf_queue
// small fifo of classified jobs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cpf_queue #(
	parameter int DEPTH = cpf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cpf_pkg::job_t push_job,
	output logic               full,
	output logic               nonempty,
	input  wire logic          pop,
	output cpf_pkg::job_t      head
);
	import cpf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/cpf_front.sv -----
// ----------------------------------------------------------------------------
// cpf_front
// accepts message bytes, runs the crc and tags packet start and end
// ----------------------------------------------------------------------------
`default_nettype none

module cpf_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	output logic                  byte_stall,
	input  wire cpf_pkg::in_item_t byte_item,
	input  wire logic             q_full,
	output logic                  q_push,
	output cpf_pkg::job_t         q_job
);
	import cpf_pkg::*;

	logic [7:0] crc_q;
	logic       in_packet_q;
	logic [7:0] crc_next;

	assign crc_next   = crc_update(crc_q, byte_item.data_byte);
	assign byte_stall = q_full;
	assign q_push     = byte_valid && !q_full;

	always_comb begin
		q_job.data = byte_item.data_byte;
		q_job.crc  = crc_next;
		q_job.open = !in_packet_q;
		q_job.last = byte_item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= INIT;
			in_packet_q <= 1'b0;
		end else if (q_push) begin
			crc_q       <= byte_item.last_byte ? INIT : crc_next;
			in_packet_q <= !byte_item.last_byte;
		end
	end

endmodule

`default_nettype wire

// ----- src/cpf_back.sv -----
// ----------------------------------------------------------------------------
// cpf_back
// serializes one job: opening marker if it opens, escaped data, and escaped crc and closing marker if last
// ----------------------------------------------------------------------------
`default_nettype none

module cpf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_nonempty,
	input  wire cpf_pkg::job_t  q_head,
	output logic                q_pop,
	output logic                line_valid,
	input  wire logic           line_stall,
	output cpf_pkg::out_item_t  line_item
);
	import cpf_pkg::*;

	localparam logic [2:0] PH_OPEN  = 3'd0;
	localparam logic [2:0] PH_DATA  = 3'd1;
	localparam logic [2:0] PH_DATA2 = 3'd2;
	localparam logic [2:0] PH_CRC   = 3'd3;
	localparam logic [2:0] PH_CRC2  = 3'd4;
	localparam logic [2:0] PH_CLOSE = 3'd5;

	job_t       job_q;
	logic       busy_q;
	logic [2:0] phase_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       advance;
	logic       emit;
	logic       done;
	logic       data_tail;
	logic [2:0] phase_nxt;
	out_item_t  emit_item;

	assign advance = !out_valid_q || !line_stall;
	assign emit    = busy_q && advance;
	assign q_pop   = q_nonempty && advance && (!busy_q || done);

	always_comb begin
		emit_item.line_byte  = MARKER;
		emit_item.run_last   = 1'b0;
		emit_item.packet_end = 1'b0;
		phase_nxt            = phase_q;
		done                 = 1'b0;
		data_tail            = 1'b0;
		case (phase_q)
			PH_OPEN: begin
				phase_nxt = PH_DATA;
			end
			PH_DATA: begin
				if (needs_escape(job_q.data)) begin
					emit_item.line_byte = ESCAPE;
					phase_nxt           = PH_DATA2;
				end else begin
					emit_item.line_byte = job_q.data;
					data_tail           = 1'b1;
				end
			end
			PH_DATA2: begin
				emit_item.line_byte = job_q.data ^ FLIP;
				data_tail           = 1'b1;
			end
			PH_CRC: begin
				if (needs_escape(job_q.crc)) begin
					emit_item.line_byte = ESCAPE;
					phase_nxt           = PH_CRC2;
				end else begin
					emit_item.line_byte = job_q.crc;
					phase_nxt           = PH_CLOSE;
				end
			end
			PH_CRC2: begin
				emit_item.line_byte = job_q.crc ^ FLIP;
				phase_nxt           = PH_CLOSE;
			end
			PH_CLOSE: begin
				emit_item.run_last   = 1'b1;
				emit_item.packet_end = 1'b1;
				done                 = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
		// after the data byte: go on to the crc or finish the job
		if (data_tail) begin
			if (job_q.last) begin
				phase_nxt = PH_CRC;
			end else begin
				emit_item.run_last = 1'b1;
				done               = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_OPEN;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q  <= 1'b1;
				phase_q <= q_head.open ? PH_OPEN : PH_DATA;
			end else if (emit && done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				phase_q <= phase_nxt;
			end
		end
	end

	assign line_valid = out_valid_q;
	assign line_item  = out_q;

endmodule

`default_nettype wire

// ----- src/cpf_checker.sv -----
// ----------------------------------------------------------------------------
// cpf_checker
// port-level checks on the framer's line output
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               line_valid,
	input wire logic               line_stall,
	input wire cpf_pkg::out_item_t line_item
);
	import cpf_pkg::*;

	// a stalled transaction stays offered
	`CHK_ASSERT_NEXT(a_valid_hold, line_valid && line_stall, line_valid, "line_valid dropped under stall")
	`CHK_ASSERT_NEXT(a_item_hold, line_valid && line_stall, $stable(line_item), "line_item changed under stall")
	// closing marker is the marker byte and ends its run
	`CHK_ASSERT(a_close, !(line_valid && line_item.packet_end) || (line_item.run_last && line_item.line_byte == MARKER), "bad closing marker")
	// an escape byte never ends a run or a packet
	`CHK_ASSERT(a_escape, !(line_valid && line_item.line_byte == ESCAPE) || (!line_item.run_last && !line_item.packet_end), "escape byte ends a run")

endmodule

bind crc8_escaped_packet_framer_unit cpf_checker u_cpf_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// framer check: message bytes in, escaped line bytes with crc-8 trailer out
// ----------------------------------------------------------------------------
// each accepted message byte goes through a local framing model
// expected line bytes wait in a queue, oldest first
// a monitor compares every accepted line byte field by field
// directed packets, random packets under four idle patterns, then one long packet
`default_nettype none

module tb;
	import cpf_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      line_valid;
	logic      line_stall = 1'b0;
	out_item_t line_item;

	// model state: running crc and whether an opening marker went out
	logic [7:0] crc_run = INIT;
	logic       packet_open = 1'b0;

	out_item_t  line_bytes_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int bytes_sent = 0;
	int packets_sent = 0;
	int line_bytes_seen = 0;
	int escapes_seen = 0;

	crc8_escaped_packet_framer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line_item  (line_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// the run must end well before this, even with the heaviest idling
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// reflected crc-8, lsb of the data first
	function automatic logic [7:0] crc8_maxim_next(input logic [7:0] acc,
		input logic [7:0] d);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = {1'b0, r[7:1]};
			if (fb) begin
				r = r ^ POLY;
			end
		end
		return r;
	endfunction

	function automatic void due_line_byte(input logic [7:0] b, input logic fin);
		out_item_t o;
		o.line_byte = b;
		o.run_last = 1'b0;
		o.packet_end = fin;
		line_bytes_due.push_back(o);
	endfunction

	// marker and escape bytes go out as escape, byte ^ flip
	function automatic void due_stuffed(input logic [7:0] b);
		if (b == MARKER || b == ESCAPE) begin
			due_line_byte(ESCAPE, 1'b0);
			due_line_byte(b ^ FLIP, 1'b0);
		end else begin
			due_line_byte(b, 1'b0);
		end
	endfunction

	// expected line bytes for one accepted message byte
	function automatic void frame_message_byte(input in_item_t it);
		out_item_t tail;
		if (!packet_open) begin
			due_line_byte(MARKER, 1'b0);
			packet_open = 1'b1;
		end
		crc_run = crc8_maxim_next(crc_run, it.data_byte);
		due_stuffed(it.data_byte);
		if (it.last_byte) begin
			due_stuffed(crc_run);
			due_line_byte(MARKER, 1'b1);
			crc_run = INIT;
			packet_open = 1'b0;
			packets_sent++;
		end
		// the final line byte of this transaction carries run_last
		tail = line_bytes_due.pop_back();
		tail.run_last = 1'b1;
		line_bytes_due.push_back(tail);
	endfunction

	// one message byte transaction, with a random gap in front of it
	task automatic send_byte(input logic [7:0] d, input logic fin);
		in_item_t it;
		it.data_byte = d;
		it.last_byte = fin;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
		frame_message_byte(it);
		bytes_sent++;
	endtask

	task automatic check_line_byte(input out_item_t got);
		out_item_t want;
		line_bytes_seen++;
		if (got.line_byte == ESCAPE) begin
			escapes_seen++;
		end
		if (line_bytes_due.size() == 0) begin
			$display("%0t: unexpected line byte, expected none, actual %02h/%b/%b",
				$time, got.line_byte, got.run_last, got.packet_end);
			errors++;
		end else begin
			want = line_bytes_due.pop_front();
			if (want.line_byte !== got.line_byte) begin
				$display("%0t: line_byte expected %02h actual %02h",
					$time, want.line_byte, got.line_byte);
				errors++;
			end
			if (want.run_last !== got.run_last) begin
				$display("%0t: run_last expected %b actual %b",
					$time, want.run_last, got.run_last);
				errors++;
			end
			if (want.packet_end !== got.packet_end) begin
				$display("%0t: packet_end expected %b actual %b",
					$time, want.packet_end, got.packet_end);
				errors++;
			end
		end
	endtask

	// line byte monitor: compare, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && line_valid && !line_stall) begin
			check_line_byte(line_item);
		end
		line_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// byte d such that one crc step from start over d equals target
	function automatic logic [7:0] byte_for_crc(input logic [7:0] start,
		input logic [7:0] target);
		logic [7:0] hit;
		hit = 8'h00;
		for (int d = 0; d < 256; d++) begin
			if (crc8_maxim_next(start, d[7:0]) == target) begin
				hit = d[7:0];
			end
		end
		return hit;
	endfunction

	// mostly random bytes, with a heavy share of marker and escape values
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		if ($urandom_range(3) == 0) begin
			b = $urandom_range(1) ? MARKER : ESCAPE;
		end else begin
			b = 8'($urandom_range(255));
		end
		return b;
	endfunction

	// random packets, ending on a packet boundary
	task automatic random_packets(input int count);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
			if (len > left) begin
				len = left;
			end
			for (int k = 0; k < len; k++) begin
				send_byte(pick_byte(), k == len - 1);
			end
			left -= len;
		end
	endtask

	// single-byte packets: opening marker, data, crc and closing marker in one
	task automatic test_single_byte_packets();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(MARKER, 1'b1);
	endtask

	// escape of marker and escape data bytes, neighbors left as they are
	task automatic test_escaped_data();
		send_byte(MARKER, 1'b0);
		send_byte(ESCAPE, 1'b0);
		send_byte(8'hFC, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(FLIP, 1'b0);
		send_byte(8'hDE, 1'b0);
		send_byte(ESCAPE, 1'b1);
	endtask

	// crc trailer that itself needs escaping
	task automatic test_escaped_crc();
		send_byte(byte_for_crc(INIT, MARKER), 1'b1);
		send_byte(byte_for_crc(INIT, ESCAPE), 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(byte_for_crc(crc8_maxim_next(INIT, 8'h55), MARKER), 1'b1);
	endtask

	// one long packet, the crc keeps running with no length limit
	task automatic test_long_packet();
		send_idle_pct = 23;
		recv_stall_pct = 23;
		for (int k = 0; k < 60; k++) begin
			send_byte(pick_byte(), k == 59);
		end
	endtask

	task automatic test_random_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_packets(70);
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct = 64;
		recv_stall_pct = 0;
		random_packets(70);
	endtask

	task automatic test_random_receiver_stalls();
		send_idle_pct = 0;
		recv_stall_pct = 64;
		random_packets(70);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct = 23;
		recv_stall_pct = 23;
		random_packets(70);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_single_byte_packets();
		test_escaped_data();
		test_escaped_crc();
		test_random_no_idle();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();
		test_long_packet();

		byte_valid <= 1'b0;
		while (line_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		// wait on so that any stray line byte gets caught
		repeat (20) @(posedge clk);

		$display("covered %0d message bytes in %0d packets under four idle patterns",
			bytes_sent, packets_sent);
		$display("compared %0d line bytes, %0d of them escape bytes",
			line_bytes_seen, escapes_seen);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- crc8_escaped_packet_framer_unit.f -----
+incdir+src
src/cpf_pkg.sv
src/cpf_queue.sv
src/cpf_front.sv
src/cpf_back.sv
src/crc8_escaped_packet_framer_unit.sv
src/cpf_checker.sv
test/tb.sv
